@@ sv/sdqp_pkg.sv @@
// Shared constants, register codes and control types for the SNR quantizer packer.
package sdqp_pkg;

	localparam int DEF_SAMPLE_WIDTH = 16;
	localparam int DEF_PACK_WIDTH   = 64;

	localparam int CODE_BITS_W = 7;
	localparam int ABS_W       = 16;
	localparam int DIFF_W      = 17;
	localparam int CFG_W       = 17;
	localparam int CFG_IDX_W   = 3;
	localparam int DIV_W       = 17;
	localparam int STATUS_W    = 2;
	localparam int BITS_USED_W = 7;

	localparam logic [CODE_BITS_W-1:0] MAX_CODE_BITS = 7'd64;

	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BITS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIFF_BITS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ABS_LOW      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ABS_HIGH     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIFF_LOW     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIFF_HIGH    = 3'd5;

	localparam logic [CODE_BITS_W-1:0] RST_INITIAL_BITS = 7'd6;
	localparam logic [CODE_BITS_W-1:0] RST_DIFF_BITS    = 7'd4;
	localparam logic signed [ABS_W-1:0]  RST_ABS_LOW   = -16'sd1280;
	localparam logic signed [ABS_W-1:0]  RST_ABS_HIGH  = 16'sd7680;
	localparam logic signed [DIFF_W-1:0] RST_DIFF_LOW  = -17'sd1280;
	localparam logic signed [DIFF_W-1:0] RST_DIFF_HIGH = 17'sd1280;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd2;

	typedef struct packed {
		logic pack;
		logic mark_ovf;
		logic mark_inv;
		logic clear;
	} pk_cmd_t;

endpackage

@@ sv/sdqp_serial_div.sv @@
// Radix-2 serial quantizer divider: floor(n*2^w/d) one bit a cycle, then round-half-up fix.
module sdqp_serial_div #(
	parameter int QW = sdqp_pkg::DEF_PACK_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [sdqp_pkg::DIV_W-1:0]         n,
	input  logic [sdqp_pkg::DIV_W-1:0]         d,
	input  logic [sdqp_pkg::CODE_BITS_W-1:0]   w,
	output logic                               done,
	output logic [QW-1:0]                      code
);
	import sdqp_pkg::*;

	localparam logic [1:0] DV_IDLE = 2'd0;
	localparam logic [1:0] DV_RUN  = 2'd1;
	localparam logic [1:0] DV_CORR = 2'd2;

	logic [1:0]             st_q;
	logic [DIV_W-1:0]       rem_q;
	logic [DIV_W-1:0]       den_q;
	logic [DIV_W-1:0]       num_q;
	logic [CODE_BITS_W-1:0] cnt_q;
	logic [QW-1:0]          quo_q;
	logic                   full_q;
	logic                   done_q;
	logic [QW-1:0]          code_q;

	logic [DIV_W:0]   p2;
	logic [DIV_W:0]   p_sub;
	logic             ge;
	logic             qbit;
	logic [DIV_W+1:0] lhs;
	logic [DIV_W+1:0] two_n;
	logic [DIV_W+1:0] two_r;
	logic [DIV_W+1:0] rhs;
	logic             adj_dn;
	logic             adj_up;
	logic [QW-1:0]    code_fix;

	always_comb begin
		p2    = {rem_q, 1'b0};
		ge    = p2 >= {1'b0, den_q};
		p_sub = p2 - {1'b0, den_q};
		qbit  = full_q | ge;
	end

	// Remainder of n*2^w/d decides whether the rounded result is one off the quotient.
	always_comb begin
		two_r  = {1'b0, rem_q, 1'b0};
		two_n  = (DIV_W+2)'({num_q, 1'b0});
		lhs    = two_r + (DIV_W+2)'(den_q);
		rhs    = (DIV_W+2)'(den_q) + two_n;
		adj_dn = lhs < two_n;
		adj_up = two_r >= rhs;
		if (full_q) begin
			code_fix = quo_q;
		end else if (adj_dn) begin
			code_fix = quo_q - QW'(1);
		end else if (adj_up) begin
			code_fix = quo_q + QW'(1);
		end else begin
			code_fix = quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= DV_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				DV_IDLE: begin
					if (start) begin
						cnt_q <= w;
						st_q  <= DV_RUN;
					end
				end
				DV_RUN: begin
					cnt_q <= cnt_q - CODE_BITS_W'(1);
					if (cnt_q == CODE_BITS_W'(1)) begin
						st_q <= DV_CORR;
					end
				end
				DV_CORR: begin
					done_q <= 1'b1;
					st_q   <= DV_IDLE;
				end
				default: begin
					st_q <= DV_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == DV_IDLE && start) begin
			rem_q  <= n;
			den_q  <= d;
			num_q  <= n;
			quo_q  <= '0;
			full_q <= (n == d);
		end else if (st_q == DV_RUN) begin
			rem_q <= ge ? p_sub[DIV_W-1:0] : p2[DIV_W-1:0];
			quo_q <= {quo_q[QW-2:0], qbit};
		end
		if (st_q == DV_CORR) begin
			code_q <= code_fix;
		end
	end

	assign done = done_q;
	assign code = code_q;

endmodule

@@ sv/sdqp_packer.sv @@
// Frame accumulator: places codes LSB-first and tracks bit position and error flags.
module sdqp_packer #(
	parameter  int PW = sdqp_pkg::DEF_PACK_WIDTH,
	localparam int PB = $clog2(PW + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sdqp_pkg::pk_cmd_t                cmd,
	input  logic [PW-1:0]                    code,
	input  logic [sdqp_pkg::CODE_BITS_W-1:0] w,
	output logic [PW-1:0]                    acc,
	output logic [PB-1:0]                    pos,
	output logic                             ovf,
	output logic                             inv
);
	import sdqp_pkg::*;

	logic [PW-1:0] acc_q;
	logic [PB-1:0] pos_q;
	logic          ovf_q;
	logic          inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pos_q <= '0;
			ovf_q <= 1'b0;
			inv_q <= 1'b0;
		end else if (cmd.clear) begin
			acc_q <= '0;
			pos_q <= '0;
			ovf_q <= 1'b0;
			inv_q <= 1'b0;
		end else begin
			if (cmd.pack) begin
				acc_q <= acc_q | (code << pos_q);
				pos_q <= pos_q + PB'(w);
			end
			if (cmd.mark_ovf) begin
				ovf_q <= 1'b1;
				pos_q <= PB'(PW);
			end
			if (cmd.mark_inv) begin
				inv_q <= 1'b1;
			end
		end
	end

	assign acc = acc_q;
	assign pos = pos_q;
	assign ovf = ovf_q;
	assign inv = inv_q;

endmodule

@@ sv/snr_differential_quantizer_packer_core.sv @@
// Top level of the SNR differential quantizer packer: control, clamp stage and result register.
//
// Usage:
//   Input stream (s_*): one SNR sample per item, tlast marks the final sample of a frame.
//   The first sample of a frame is clamped to the absolute range and quantized to the
//   initial code width; each later sample is coded as its clamped difference from the
//   previous raw sample at the difference code width. Codes pack LSB-first.
//   Output stream (m_*): one item per frame, issued after the tlast sample. tuser carries
//   the status (ok, overflow, invalid configuration).
//   Configuration: cfg_we/cfg_index/cfg_wdata, write only while the block is idle.
// Sequence:
//   A packed sample is worked through before the next is accepted; its time grows with w,
//   the code width in use, as set by the serial divider, one quotient bit a cycle.
//   A sample that packs nothing (overflow or bad configuration) skips the divider.
//   The result of a frame is registered onto m_tvalid from the final step of its tlast
//   sample, after the divider when that sample packs a code.
// Reset and stalls:
//   arst_n clears the frame state, restores the default registers and drops m_tvalid.
//   A result waits in the output register; the block keeps taking samples of the next
//   frame and holds only when a second result is ready while the first is still untaken.
module snr_differential_quantizer_packer_core #(
	parameter  int SAMPLE_WIDTH = sdqp_pkg::DEF_SAMPLE_WIDTH,
	parameter  int PACK_WIDTH   = sdqp_pkg::DEF_PACK_WIDTH,
	localparam int IN_DATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8,
	localparam int OUT_DATA_W   = ((PACK_WIDTH + sdqp_pkg::BITS_USED_W + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [sdqp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sdqp_pkg::CFG_W-1:0]     cfg_wdata,
	// sample stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [IN_DATA_W-1:0]           s_tdata,   // [SAMPLE_WIDTH-1:0] sample
	input  logic                           s_tlast,
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [OUT_DATA_W-1:0]          m_tdata,   // packed_res, then bits_used (7 bits)
	output logic [sdqp_pkg::STATUS_W-1:0]  m_tuser    // status
);
	import sdqp_pkg::*;

	// Wide enough for a raw difference and for the difference range registers.
	localparam int XW = (SAMPLE_WIDTH + 1 > DIV_W + 1) ? SAMPLE_WIDTH + 1 : DIV_W + 1;
	localparam int PB = $clog2(PACK_WIDTH + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLAMP = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	// configuration registers
	logic [CODE_BITS_W-1:0]    ibits_q;
	logic [CODE_BITS_W-1:0]    dbits_q;
	logic signed [ABS_W-1:0]   alo_q;
	logic signed [ABS_W-1:0]   ahi_q;
	logic signed [DIFF_W-1:0]  dlo_q;
	logic signed [DIFF_W-1:0]  dhi_q;

	// frame-spanning state
	logic [1:0]                     state_q;
	logic signed [SAMPLE_WIDTH-1:0] prev_q;
	logic                           frame_start_q;

	// sample captured at acceptance
	logic signed [XW-1:0]   x_s1;
	logic signed [XW-1:0]   lo_s1;
	logic signed [XW-1:0]   hi_s1;
	logic [CODE_BITS_W-1:0] w_s1;
	logic                   last_s1;
	logic                   ok_s1;

	// result register
	logic                   out_valid_q;
	logic [PACK_WIDTH-1:0]  out_packed_q;
	logic [STATUS_W-1:0]    out_status_q;
	logic [BITS_USED_W-1:0] out_bits_q;

	logic                           in_acc;
	logic signed [SAMPLE_WIDTH-1:0] samp;
	logic signed [XW-1:0]           samp_x;
	logic signed [XW-1:0]           prev_x;
	logic signed [XW-1:0]           diff_x;
	logic                           cfg_ok;

	logic signed [XW-1:0]   clamped;
	logic signed [XW-1:0]   n_full;
	logic signed [XW-1:0]   d_full;
	logic [CODE_BITS_W:0]   end_pos;
	logic                   fits;

	logic                   div_start;
	logic                   div_done;
	logic [PACK_WIDTH-1:0]  div_code;

	pk_cmd_t                pk_cmd;
	logic [PACK_WIDTH-1:0]  pk_acc;
	logic [PB-1:0]          pk_pos;
	logic                   pk_ovf;
	logic                   pk_inv;

	logic                   out_free;
	logic                   out_load;
	logic [PACK_WIDTH-1:0]  res_packed;
	logic [STATUS_W-1:0]    res_status;
	logic [BITS_USED_W-1:0] res_bits;

	// Registers take writes at any time; the caller keeps them still while a frame runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ibits_q <= RST_INITIAL_BITS;
			dbits_q <= RST_DIFF_BITS;
			alo_q   <= RST_ABS_LOW;
			ahi_q   <= RST_ABS_HIGH;
			dlo_q   <= RST_DIFF_LOW;
			dhi_q   <= RST_DIFF_HIGH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INITIAL_BITS: ibits_q <= cfg_wdata[CODE_BITS_W-1:0];
				REG_DIFF_BITS:    dbits_q <= cfg_wdata[CODE_BITS_W-1:0];
				REG_ABS_LOW:      alo_q   <= cfg_wdata[ABS_W-1:0];
				REG_ABS_HIGH:     ahi_q   <= cfg_wdata[ABS_W-1:0];
				REG_DIFF_LOW:     dlo_q   <= cfg_wdata[DIFF_W-1:0];
				REG_DIFF_HIGH:    dhi_q   <= cfg_wdata[DIFF_W-1:0];
				default: ;
			endcase
		end
	end

	// Acceptance: take samples only when no earlier sample is still in work.
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	always_comb begin
		samp   = s_tdata[SAMPLE_WIDTH-1:0];
		samp_x = XW'(samp);
		prev_x = XW'(prev_q);
		diff_x = samp_x - prev_x;
		cfg_ok = (ibits_q != '0) && (ibits_q <= MAX_CODE_BITS) &&
		         (dbits_q != '0) && (dbits_q <= MAX_CODE_BITS) &&
		         (alo_q < ahi_q) && (dlo_q < dhi_q);
	end

	// Capture the sample with the registers that apply to it.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			last_s1 <= s_tlast;
			ok_s1   <= cfg_ok;
			if (frame_start_q) begin
				x_s1  <= samp_x;
				lo_s1 <= XW'(alo_q);
				hi_s1 <= XW'(ahi_q);
				w_s1  <= ibits_q;
			end else begin
				x_s1  <= diff_x;
				lo_s1 <= XW'(dlo_q);
				hi_s1 <= XW'(dhi_q);
				w_s1  <= dbits_q;
			end
		end
	end

	// previous sample and frame start advance on every sample, whatever its outcome
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q        <= '0;
			frame_start_q <= 1'b1;
		end else if (in_acc) begin
			prev_q        <= samp;
			frame_start_q <= s_tlast;
		end
	end

	// Clamp stage: offset from the low bound and range span feed the divider.
	always_comb begin
		if (x_s1 < lo_s1) begin
			clamped = lo_s1;
		end else if (x_s1 > hi_s1) begin
			clamped = hi_s1;
		end else begin
			clamped = x_s1;
		end
		n_full  = clamped - lo_s1;
		d_full  = hi_s1 - lo_s1;
		end_pos = {1'b0, w_s1} + (CODE_BITS_W+1)'(pk_pos);
		fits    = end_pos <= (CODE_BITS_W+1)'(PACK_WIDTH);
	end

	assign out_free = !out_valid_q || m_tready;

	// Sequencer: clamp, divide and pack a valid code that fits, close the frame on its last sample.
	always_comb begin
		pk_cmd    = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_CLAMP: begin
				pk_cmd.mark_inv = !ok_s1;
				pk_cmd.mark_ovf = ok_s1 && (pk_ovf || !fits);
				div_start       = ok_s1 && !pk_ovf && fits;
			end
			ST_DIV: begin
				pk_cmd.pack = div_done;
			end
			ST_FIN: begin
				out_load     = last_s1 && out_free;
				pk_cmd.clear = out_load;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					state_q <= div_start ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold a frame's last sample here while the previous result is still untaken
					if (!last_s1 || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	sdqp_serial_div #(
		.QW(PACK_WIDTH)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.n     (n_full[DIV_W-1:0]),
		.d     (d_full[DIV_W-1:0]),
		.w     (w_s1),
		.done  (div_done),
		.code  (div_code)
	);

	sdqp_packer #(
		.PW(PACK_WIDTH)
	) u_packer (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (pk_cmd),
		.code  (div_code),
		.w     (w_s1),
		.acc   (pk_acc),
		.pos   (pk_pos),
		.ovf   (pk_ovf),
		.inv   (pk_inv)
	);

	// Frame result: a bad configuration outranks an overflow.
	always_comb begin
		if (pk_inv) begin
			res_packed = '0;
			res_status = STATUS_INVALID;
			res_bits   = '0;
		end else if (pk_ovf) begin
			res_packed = '0;
			res_status = STATUS_OVERFLOW;
			res_bits   = BITS_USED_W'(pk_pos);
		end else begin
			res_packed = pk_acc;
			res_status = STATUS_OK;
			res_bits   = BITS_USED_W'(pk_pos);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_packed_q <= res_packed;
			out_status_q <= res_status;
			out_bits_q   <= res_bits;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({out_bits_q, out_packed_q});
	assign m_tuser  = out_status_q;

`ifndef ASSERT_OFF
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(PB+1)'(pk_pos) <= (PB+1)'(PACK_WIDTH))
		else $error("bit position beyond pack width");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide step");

	a_clear_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (pk_pos == '0) && !pk_ovf && !pk_inv)
		else $error("frame state not cleared after result");

	a_ovf_bits_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == STATUS_OVERFLOW)) |->
		(out_bits_q == BITS_USED_W'(PACK_WIDTH)) && (out_packed_q == '0))
		else $error("overflow result with wrong bit count or data");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(div_start || pk_cmd.pack) |-> !s_tready)
		else $error("input ready while a sample is in work");
`endif

endmodule
